FILE: sv/rmta_pkg.sv
// Shared types and constants for the recursive moving trend average block.
`default_nettype none
package rmta_pkg;

   localparam int SAMPLE_W = 32;
   localparam int STATE_W  = 48;
   localparam int CNT_W    = 16;
   localparam int BETA_W   = 17;
   localparam int CSR_IDX_W = 1;

   localparam logic [BETA_W-1:0]    ONE_Q16    = 17'h10000;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BETA   = 1'b1;

   // One classified sample handed from front end to back end.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic                       seed;
      logic                       upd;
      logic                       emit;
   } rmta_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rmta_qstat_type;

endpackage
`default_nettype wire

FILE: sv/recursive_moving_trend_average.sv
// A sample passes from the front end through the queue to the back end, which works on one word at a time;
// a series start runs the seed recurrence and, when period is zero or one, the update after it.
// The back end's chain of dependent multiplies runs through its single three-stage
// multiplier; a result word held by the receiver stalls the back end in its last state.
// Reset (synchronous): period 1, beta 0, trend and average zero, queue empty, no result.
`default_nettype none
module recursive_moving_trend_average #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [rmta_pkg::SAMPLE_W-1:0]      req_tdata,  // sample
   input  wire logic [0:0]                         req_tuser,  // series_start
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [rmta_pkg::STATE_W-1:0]            rsp_tdata,  // average
   input  wire logic                               csr_we,
   input  wire logic [rmta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rmta_pkg::BETA_W-1:0]        csr_wdata
);
   import rmta_pkg::*;

   logic [CNT_W-1:0]  period_ff, period_in;
   logic [BETA_W-1:0] beta_ff, beta_in;
   logic              q_push, q_pop;
   rmta_entry_type    q_wr, q_rd;
   rmta_qstat_type    q_stat;

   always_comb begin
      period_in = period_ff;
      beta_in   = beta_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PERIOD: period_in = csr_wdata[CNT_W-1:0];
            REG_BETA:   beta_in   = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= CNT_W'(1);
         beta_ff   <= '0;
      end else begin
         period_ff <= period_in;
         beta_ff   <= beta_in;
      end
   end

   rmta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .period     (period_ff),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_entry    (q_wr)
   );

   rmta_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr),
      .pop      (q_pop),
      .rd_entry (q_rd),
      .stat     (q_stat)
   );

   rmta_back u_back (
      .clock      (clock),
      .reset      (reset),
      .beta       (beta_ff),
      .q_entry    (q_rd),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && q_stat.empty))
      else $error("result or queue word left after reset");

   a_queue_stat: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("back end popped an empty queue");

endmodule
`default_nettype wire

FILE: sv/rmta_front.sv
// Front end: accepts samples, tracks the series index and classifies each word.
`default_nettype none
module rmta_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [rmta_pkg::SAMPLE_W-1:0] req_tdata,
   input  wire logic [0:0]                    req_tuser,
   input  wire logic [rmta_pkg::CNT_W-1:0]    period,
   input  wire rmta_pkg::rmta_qstat_type      q_stat,
   output logic                               q_push,
   output rmta_pkg::rmta_entry_type           q_entry
);
   import rmta_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx;
   logic [CNT_W-1:0] per;
   logic [CNT_W:0]   idx_inc;
   logic             start;

   assign req_tready = !q_stat.full;
   assign q_push     = req_tvalid && req_tready;
   assign start      = req_tuser[0];

   always_comb begin
      per     = (period == '0) ? CNT_W'(1) : period;
      idx     = start ? '0 : cnt_ff;
      idx_inc = {1'b0, idx} + (CNT_W+1)'(1);
      cnt_in  = cnt_ff;
      if (q_push) begin
         cnt_in = (idx == '1) ? '1 : idx_inc[CNT_W-1:0];
      end
      q_entry.x    = $signed(req_tdata);
      q_entry.seed = start;
      // with a one-sample warm-up the seed word also gets the update
      q_entry.upd  = !start || (period <= CNT_W'(1));
      q_entry.emit = idx_inc >= {1'b0, per};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/rmta_fifo.sv
// Short queue of classified words between front end and back end.
`default_nettype none
module rmta_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire rmta_pkg::rmta_entry_type wr_entry,
   input  wire logic                     pop,
   output rmta_pkg::rmta_entry_type      rd_entry,
   output rmta_pkg::rmta_qstat_type      stat
);
   import rmta_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   rmta_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign rd_entry   = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/rmta_mulq.sv
// Three-stage Q1.16 by Q32.16 multiplier with round half up, 24-bit split operand.
`default_nettype none
module rmta_mulq (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               go,
   input  wire logic [rmta_pkg::BETA_W-1:0]        c,
   input  wire logic signed [rmta_pkg::STATE_W-1:0] v,
   output logic                                    done,
   output logic signed [rmta_pkg::STATE_W-1:0]     res
);
   import rmta_pkg::*;

   localparam int HALF_W = STATE_W / 2;
   localparam int LO_W   = BETA_W + HALF_W;
   localparam int HI_W   = BETA_W + 1 + HALF_W;
   localparam int SUM_W  = HI_W + HALF_W;

   logic [BETA_W-1:0]        c_ff;
   logic signed [HALF_W-1:0] vh_ff;
   logic [LO_W-1:0]          lo1_ff, lo2_ff;
   logic signed [HI_W-1:0]   hi_ff;
   logic signed [STATE_W-1:0] res_ff;
   logic                     vld1_ff, vld2_ff, done_ff;
   logic [LO_W-1:0]          lo_prod;
   logic signed [HI_W-1:0]   hi_prod;
   logic [SUM_W-1:0]         sum;

   assign lo_prod = LO_W'(c) * LO_W'(v[HALF_W-1:0]);
   assign hi_prod = $signed({1'b0, c_ff}) * vh_ff;
   // high partial product sits 24 bits up; add half an LSB of the Q16 result
   assign sum = {hi_ff, {HALF_W{1'b0}}} + {{(SUM_W-LO_W){1'b0}}, lo2_ff}
              + SUM_W'(32768);

   assign done = done_ff;
   assign res  = res_ff;

   always_ff @(posedge clock) begin
      c_ff   <= c;
      vh_ff  <= v[STATE_W-1:HALF_W];
      lo1_ff <= lo_prod;
      lo2_ff <= lo1_ff;
      hi_ff  <= hi_prod;
      res_ff <= $signed(sum[STATE_W+15:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         vld1_ff <= go;
         vld2_ff <= vld1_ff;
         done_ff <= vld2_ff;
      end
   end

endmodule
`default_nettype wire

FILE: sv/rmta_back.sv
// Back end: sequences the seed and update recurrences over the shared multiplier.
`default_nettype none
module rmta_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [rmta_pkg::BETA_W-1:0]       beta,
   input  wire rmta_pkg::rmta_entry_type          q_entry,
   input  wire rmta_pkg::rmta_qstat_type          q_stat,
   output logic                                   q_pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [rmta_pkg::STATE_W-1:0]           rsp_tdata
);
   import rmta_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_W1,
      ST_SEED_B,
      ST_SEED_S,
      ST_SEED_MUL2,
      ST_SEED_W2,
      ST_UPD_MUL1,
      ST_UPD_MUL2,
      ST_UPD_W1,
      ST_UPD_W2,
      ST_UPD_D,
      ST_UPD_MUL3,
      ST_UPD_W3,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic upd_ff, upd_in, emit_ff, emit_in;
   logic signed [STATE_W-1:0] b_ff, b_in, avg_ff, avg_in;
   logic signed [STATE_W-1:0] nb_ff, nb_in, t_ff, t_in, op_ff, op_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [BETA_W-1:0] be, al;
   logic signed [STATE_W-1:0] x48;
   logic mul_go, mul_done;
   logic [BETA_W-1:0] mul_c;
   logic signed [STATE_W-1:0] mul_v, mul_res;

   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [STATE_W+1:0] v);
      logic signed [STATE_W+1:0] hi, lo;
      hi = {3'b000, {(STATE_W-1){1'b1}}};
      lo = {3'b111, {(STATE_W-1){1'b0}}};
      if (v > hi) return {1'b0, {(STATE_W-1){1'b1}}};
      if (v < lo) return {1'b1, {(STATE_W-1){1'b0}}};
      return v[STATE_W-1:0];
   endfunction

   function automatic logic signed [STATE_W+1:0] ext(input logic signed [STATE_W-1:0] v);
      return {{2{v[STATE_W-1]}}, v};
   endfunction

   rmta_mulq u_mulq (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .c     (mul_c),
      .v     (mul_v),
      .done  (mul_done),
      .res   (mul_res)
   );

   assign be  = (beta > ONE_Q16) ? ONE_Q16 : beta;
   assign al  = ONE_Q16 - be;
   assign x48 = {{(STATE_W-SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff};

   assign q_pop      = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      upd_in       = upd_ff;
      emit_in      = emit_ff;
      b_in         = b_ff;
      avg_in       = avg_ff;
      nb_in        = nb_ff;
      t_in         = t_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_go       = 1'b0;
      mul_c        = be;
      mul_v        = x48;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               x_in     = q_entry.x;
               upd_in   = q_entry.upd;
               emit_in  = q_entry.emit;
               state_in = q_entry.seed ? ST_SEED_MUL : ST_UPD_MUL1;
            end
         end
         ST_SEED_MUL: begin
            mul_go   = 1'b1;
            state_in = ST_SEED_W1;
         end
         ST_SEED_W1: begin
            if (mul_done) begin
               t_in     = mul_res;
               state_in = ST_SEED_B;
            end
         end
         ST_SEED_B: begin
            b_in     = sat48(ext(t_ff) + ext(x48));
            state_in = ST_SEED_S;
         end
         ST_SEED_S: begin
            op_in    = sat48(ext(x48) + ext(b_ff));
            state_in = ST_SEED_MUL2;
         end
         ST_SEED_MUL2: begin
            mul_go   = 1'b1;
            mul_c    = al;
            mul_v    = op_ff;
            state_in = ST_SEED_W2;
         end
         ST_SEED_W2: begin
            if (mul_done) begin
               avg_in   = sat48(ext(t_ff) + ext(mul_res));
               state_in = upd_ff ? ST_UPD_MUL1 : ST_FINISH;
            end
         end
         ST_UPD_MUL1: begin
            mul_go   = 1'b1;
            mul_v    = b_ff;
            state_in = ST_UPD_MUL2;
         end
         ST_UPD_MUL2: begin
            // second product rides one stage behind the first
            mul_go   = 1'b1;
            mul_v    = avg_ff;
            state_in = ST_UPD_W1;
         end
         ST_UPD_W1: begin
            if (mul_done) begin
               nb_in    = sat48(ext(mul_res) + ext(x48));
               state_in = ST_UPD_W2;
            end
         end
         ST_UPD_W2: begin
            if (mul_done) begin
               t_in     = mul_res;
               state_in = ST_UPD_D;
            end
         end
         ST_UPD_D: begin
            op_in    = sat48(ext(x48) + ext(nb_ff) - ext(b_ff));
            state_in = ST_UPD_MUL3;
         end
         ST_UPD_MUL3: begin
            mul_go   = 1'b1;
            mul_c    = al;
            mul_v    = op_ff;
            b_in     = nb_ff;
            state_in = ST_UPD_W3;
         end
         ST_UPD_W3: begin
            if (mul_done) begin
               avg_in   = sat48(ext(t_ff) + ext(mul_res));
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = avg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         b_ff         <= '0;
         avg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         b_ff         <= b_in;
         avg_ff       <= avg_in;
      end
      x_ff        <= x_in;
      upd_ff      <= upd_in;
      emit_ff     <= emit_in;
      nb_ff       <= nb_in;
      t_ff        <= t_in;
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

FILE: dv/tb_recursive_moving_trend_average.sv
// Self-checking testbench for the recursive moving trend average block.
`default_nettype none
module tb_recursive_moving_trend_average;
   import rmta_pkg::*;

   localparam int RANDOM_ITEMS = 1400;
   localparam int LONG_SERIES  = 64;
   localparam int QUIET_CYCLES = 60;    // covers a seed with period one still in flight
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 10;

   // Keeps its own copy of the trend state and predicts the average words.
   class rmta_scoreboard;
      longint      trend;
      longint      avg;
      int unsigned count;
      int unsigned period_q;
      int unsigned beta_q;
      logic [STATE_W-1:0] expected_averages[$];
      int          mismatches;

      function new();
         trend      = 0;
         avg        = 0;
         count      = 0;
         period_q   = 1;
         beta_q     = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [BETA_W-1:0] val);
         if (idx == REG_PERIOD) begin
            period_q = 32'(val[15:0]);
         end else begin
            beta_q = 32'(val);
         end
      endfunction

      static function longint sat48(longint v);
         if (v > 64'sd140737488355327) begin
            return 64'sd140737488355327;
         end
         if (v < -64'sd140737488355328) begin
            return -64'sd140737488355328;
         end
         return v;
      endfunction

      // Q1.16 factor times Q32.16 value, rounded half up.
      static function longint scale_q16(longint c, longint v);
         return (c * v + 32768) >>> 16;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] s, logic start);
         longint      x;
         longint      be;
         longint      al;
         longint      nb;
         longint      d;
         int unsigned idx;
         int unsigned per;
         bit          upd;
         x   = longint'($signed(s));
         be  = (beta_q > int'(ONE_Q16)) ? longint'(ONE_Q16) : longint'(beta_q);
         al  = longint'(ONE_Q16) - be;
         per = (period_q == 0) ? 1 : period_q;
         upd = 1'b1;
         if (start) begin
            idx   = 0;
            trend = sat48(scale_q16(be, x) + x);
            avg   = sat48(scale_q16(be, x) + scale_q16(al, sat48(x + trend)));
            upd   = (per <= 1);
         end else begin
            idx = count;
         end
         if (upd) begin
            nb    = sat48(scale_q16(be, trend) + x);
            d     = sat48(x + nb - trend);
            avg   = sat48(scale_q16(be, avg) + scale_q16(al, d));
            trend = nb;
         end
         count = (idx >= 65535) ? 65535 : idx + 1;
         if (idx + 1 >= per) begin
            expected_averages.push_back(STATE_W'(avg));
         end
      endfunction

      function void check_average(logic [STATE_W-1:0] got);
         logic [STATE_W-1:0] want;
         if (expected_averages.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected average word %h", got);
            end
         end else begin
            want = expected_averages.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("average mismatch: expected %h, got %h", want, got);
               end
            end
         end
      endfunction

      function int pending();
         return expected_averages.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;   // sample
   logic [0:0]            req_tuser;   // series_start
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [STATE_W-1:0]    rsp_tdata;   // average
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [BETA_W-1:0]     csr_wdata;

   rmta_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_cycles;

   recursive_moving_trend_average i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Input words are noted before result words so a prediction is always queued first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_sample(req_tdata, req_tuser[0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_average(rsp_tdata);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Called and returns at a falling edge.
   task automatic send_word(logic [SAMPLE_W-1:0] s, bit start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= s;
      req_tuser[0] <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [BETA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Stop sending until every predicted word is out, optionally let stragglers finish.
   task automatic wait_drained(bit settle);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      if (settle) begin
         repeat (QUIET_CYCLES) @(posedge clock);
      end
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int k;
      k = $urandom_range(99);
      if (k < 10) begin
         return 32'h7FFF_FFFF;
      end else if (k < 20) begin
         return 32'h8000_0000;
      end else if (k < 35) begin
         return SAMPLE_W'($signed($urandom_range(1023)) - 512) << 16;
      end
      return $urandom;
   endfunction

   initial begin
      int sent;
      int phase_len;
      int n;
      int series_len;
      int k;
      bit broken;
      logic [15:0] per;
      logic [BETA_W-1:0] beta;

      sb            = new();
      send_idle_pct = 13;
      recv_idle_pct = 52;
      stall_cycles  = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      csr_we        = 1'b0;
      csr_index     = REG_PERIOD;
      csr_wdata     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no series start yet: continues from the all-zero state
      send_word(32'h0001_0000, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b0);
      wait_drained(1'b1);

      write_csr(REG_PERIOD, 17'd1);
      write_csr(REG_BETA, ONE_Q16);
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      wait_drained(1'b1);

      write_csr(REG_PERIOD, 17'd3);
      write_csr(REG_BETA, 17'd0);
      send_word(32'h1234_5678, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      wait_drained(1'b1);

      // period changed while a series is running
      write_csr(REG_PERIOD, 17'd2);
      write_csr(REG_BETA, 17'd32769);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      wait_drained(1'b1);

      write_csr(REG_PERIOD, 17'd65535);
      write_csr(REG_BETA, 17'd1);
      send_word(32'h7FFF_FFFF, 1'b1);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      wait_drained(1'b1);

      write_csr(REG_PERIOD, 17'd1);
      write_csr(REG_BETA, 17'd65535);
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h7FFF_FFFF, 1'b1);
      send_word(32'h0000_0000, 1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 52;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_drained(1'b1);

         k = $urandom_range(99);
         if (k < 70) begin
            per = 16'($urandom_range(4, 1));
         end else if (k < 90) begin
            per = 16'($urandom_range(30, 5));
         end else if (k < 97) begin
            per = 16'($urandom_range(65535, 31));
         end else begin
            per = 16'hFFFF;
         end
         k = $urandom_range(99);
         if (k < 25) begin
            beta = '0;
         end else if (k < 50) begin
            beta = ONE_Q16;
         end else begin
            beta = BETA_W'($urandom_range(65536, 0));
         end
         // sometimes one register only, so running series see a changed setting
         k = $urandom_range(9);
         if (k != 0) begin
            write_csr(REG_PERIOD, {1'b0, per});
         end
         if (k != 1) begin
            write_csr(REG_BETA, beta);
         end

         phase_len = $urandom_range(90, 30);
         n = 0;
         while (n < phase_len) begin
            series_len = $urandom_range(16, 1);
            broken = ($urandom_range(9) == 0);
            for (int j = 0; j < series_len; j++) begin
               send_word(pick_sample(), (j == 0) && !broken);
               n++;
               sent++;
               if ($urandom_range(99) < 2) begin
                  wait_drained(1'b0);
               end
            end
         end
      end

      // long series at beta one: the trend keeps growing toward the negative limit
      wait_drained(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(REG_PERIOD, 17'd2);
      write_csr(REG_BETA, ONE_Q16);
      for (int j = 0; j < LONG_SERIES; j++) begin
         send_word(32'h8000_0000 + $urandom_range(255), j == 0);
      end
      wait_drained(1'b1);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
